// ----- src/ipq_pkg.sv -----
// Shared types and defaults for the indexed packet queue.
`timescale 1ns / 1ps

package ipq_pkg;

  localparam int unsigned DEPTH_DEFAULT        = 32;
  localparam int unsigned PAYLOAD_BITS_DEFAULT = 32;

  localparam int unsigned POS_BITS   = 6;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 6;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_INS = 2'd2,
    OP_REM = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// ----- src/ipq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ipq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/indexed_packet_queue_top.sv -----
// Indexed packet queue: enqueue, dequeue, insert and remove over one RAM.
// Enqueue and rejected requests strobe the result on the cycle after acceptance.
// A tail insert goes to S_PUT; others shift up in S_UP, S_UP_LAST, then S_PUT. Remove and
// dequeue shift down in S_DOWN, S_DOWN_LAST; the single RAM port pair moves one entry a
// cycle. busy is low again while the result strobe is shown. The receiver cannot stall.
// Reset clears the entry count; RAM contents stay undefined until written.
`timescale 1ns / 1ps

module indexed_packet_queue_top
  import ipq_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEFAULT,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic [POS_BITS-1:0]   position_i,
  input  logic [WORD_BITS-1:0]  payload_in_i,
  output logic                  done_o,
  output logic                  payload_valid_o,
  output logic [WORD_BITS-1:0]  payload_out_o,
  output logic [1:0]            status_o,
  output logic [COUNT_BITS-1:0] entry_count_o,
  output logic                  is_empty_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_LAST,
    S_PUT,
    S_DOWN,
    S_DOWN_LAST
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic [AW-1:0]           ptr_q;
  logic [AW-1:0]           pos_q;
  logic [AW-1:0]           last_q;
  logic [AW-1:0]           wr_addr_q;
  logic                    pend_q;
  logic                    cap_q;
  logic [PAYLOAD_BITS-1:0] word_q;
  logic [PAYLOAD_BITS-1:0] result_q;
  logic                    valid_q;
  status_e                 status_q;
  logic                    done_q;

  logic                    accept;
  op_e                     op_in;
  logic [CMPW-1:0]         pos_ext;
  logic [CMPW-1:0]         cnt_ext;
  logic                    full;
  logic [63:0]             word_ext;
  logic [PAYLOAD_BITS-1:0] word_in;
  logic [63:0]             result_ext;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [PAYLOAD_BITS-1:0] ram_wdata;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  assign accept   = start && !busy;
  assign op_in    = op_e'(operation_i);
  assign pos_ext  = CMPW'(position_i);
  assign cnt_ext  = CMPW'(count_q);
  assign full     = (count_q == CW'(DEPTH));
  assign word_ext = 64'(payload_in_i);
  assign word_in  = word_ext[PAYLOAD_BITS-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = ram_rdata;
    if (pend_q) begin
      ram_we = 1'b1;
    end else if (state_q == S_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q;
      ram_wdata = word_q;
    end else if (accept && op_in == OP_ENQ && !full) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(count_q);
      ram_wdata = word_in;
    end
  end

  ipq_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      pos_q     <= '0;
      last_q    <= '0;
      wr_addr_q <= '0;
      pend_q    <= 1'b0;
      cap_q     <= 1'b0;
      valid_q   <= 1'b0;
      status_q  <= ST_OK;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      pend_q <= 1'b0;
      cap_q  <= 1'b0;
      if (cap_q) begin
        result_q <= ram_rdata;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            result_q <= '0;
            valid_q  <= 1'b0;
            status_q <= ST_OK;
            word_q   <= word_in;
            pos_q    <= AW'(position_i);
            unique case (op_in)
              OP_ENQ: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              OP_DEQ: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  done_q   <= 1'b1;
                end else begin
                  pos_q   <= '0;
                  ptr_q   <= '0;
                  last_q  <= AW'(count_q - CW'(1));
                  state_q <= S_DOWN;
                end
              end
              OP_INS: begin
                if (pos_ext > cnt_ext) begin
                  status_q <= ST_RANGE;
                  done_q   <= 1'b1;
                end else if (full) begin
                  status_q <= ST_FULL;
                  done_q   <= 1'b1;
                end else if (pos_ext == cnt_ext) begin
                  state_q <= S_PUT;
                end else begin
                  ptr_q   <= AW'(count_q - CW'(1));
                  state_q <= S_UP;
                end
              end
              OP_REM: begin
                if (pos_ext >= cnt_ext) begin
                  status_q <= ST_RANGE;
                  done_q   <= 1'b1;
                end else begin
                  ptr_q   <= AW'(position_i);
                  last_q  <= AW'(count_q - CW'(1));
                  state_q <= S_DOWN;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_UP: begin
          pend_q    <= 1'b1;
          wr_addr_q <= ptr_q + AW'(1);
          if (ptr_q == pos_q) begin
            state_q <= S_UP_LAST;
          end else begin
            ptr_q <= ptr_q - AW'(1);
          end
        end
        S_UP_LAST: begin
          state_q <= S_PUT;
        end
        S_PUT: begin
          count_q <= count_q + CW'(1);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_DOWN: begin
          cap_q     <= (ptr_q == pos_q);
          pend_q    <= (ptr_q != pos_q);
          wr_addr_q <= ptr_q - AW'(1);
          if (ptr_q == last_q) begin
            state_q <= S_DOWN_LAST;
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
        S_DOWN_LAST: begin
          count_q <= count_q - CW'(1);
          valid_q <= 1'b1;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_ext      = 64'(result_q);
  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign payload_valid_o = valid_q;
  assign payload_out_o   = result_ext[WORD_BITS-1:0];
  assign status_o        = status_q;
  assign entry_count_o   = COUNT_BITS'(count_q);
  assign is_empty_o      = (count_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP || state_q == S_DOWN) && ram_we |-> ram_waddr != ptr_q)
    else $error("shift writes the entry being read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && payload_valid_o |-> status_o == ST_OK)
    else $error("returned payload on a rejected request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy || done_o)
    else $error("accepted request neither in progress nor answered");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> done_q)
    else $error("entry count changed without a result");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the indexed packet queue: directed, full-queue and random requests.
`timescale 1ns / 1ps

module tb_top;
  import ipq_pkg::*;

  localparam int unsigned QDEPTH    = DEPTH_DEFAULT;
  localparam int unsigned WORD_KEEP = PAYLOAD_BITS_DEFAULT;
  localparam logic [WORD_BITS-1:0] KEEP_MASK =
    (WORD_KEEP >= WORD_BITS) ? '1 : ((WORD_BITS'(1) << WORD_KEEP) - 1);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * QDEPTH + 8;

  typedef struct packed {
    logic                  valid;
    logic [WORD_BITS-1:0]  word;
    status_e               status;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } outcome_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            operation_i = OP_ENQ;
  logic [POS_BITS-1:0]   position_i = '0;
  logic [WORD_BITS-1:0]  payload_in_i = '0;
  logic                  done_o;
  logic                  payload_valid_o;
  logic [WORD_BITS-1:0]  payload_out_o;
  logic [1:0]            status_o;
  logic [COUNT_BITS-1:0] entry_count_o;
  logic                  is_empty_o;

  logic [WORD_BITS-1:0] held_words[$];
  outcome_t             pending_outcomes[$];
  outcome_t             oldest;
  int unsigned          idle_pct = 0;
  int unsigned          mismatches = 0;
  int unsigned          requests_sent = 0;
  int unsigned          results_checked = 0;
  int unsigned          deepest_fill = 0;
  int unsigned          status_seen[4] = '{0, 0, 0, 0};
  int unsigned          cycle_count = 0;

  indexed_packet_queue_top #(
    .DEPTH       (QDEPTH),
    .PAYLOAD_BITS(WORD_KEEP)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .payload_in_i   (payload_in_i),
    .done_o         (done_o),
    .payload_valid_o(payload_valid_o),
    .payload_out_o  (payload_out_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic outcome_t predict_queue_op(op_e op, logic [POS_BITS-1:0] pos,
                                                logic [WORD_BITS-1:0] data);
    outcome_t r;
    int unsigned n;
    int unsigned p;
    r = '0;
    r.status = ST_OK;
    n = held_words.size();
    p = int'(pos);
    case (op)
      OP_ENQ: begin
        if (n >= QDEPTH) r.status = ST_FULL;
        else held_words.push_back(data & KEEP_MASK);
      end
      OP_DEQ: begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          r.valid = 1'b1;
          r.word  = held_words.pop_front();
        end
      end
      OP_INS: begin
        if (p > n) r.status = ST_RANGE;
        else if (n >= QDEPTH) r.status = ST_FULL;
        else held_words.insert(p, data & KEEP_MASK);
      end
      default: begin
        if (p >= n) r.status = ST_RANGE;
        else begin
          r.valid = 1'b1;
          r.word  = held_words[p];
          held_words.delete(p);
        end
      end
    endcase
    r.count = COUNT_BITS'(held_words.size());
    r.empty = (held_words.size() == 0);
    if (held_words.size() > deepest_fill) deepest_fill = held_words.size();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_BITS-1:0] got,
                                 input logic [WORD_BITS-1:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h (result %0d, %0t)", field, got, want,
             results_checked, $time);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result strobe", {30'd0, status_o}, '0);
      end else begin
        oldest = pending_outcomes.pop_front();
        status_seen[oldest.status]++;
        results_checked++;
        if (payload_valid_o !== oldest.valid)
          report_mismatch("payload_valid", WORD_BITS'(payload_valid_o), WORD_BITS'(oldest.valid));
        if (payload_out_o !== oldest.word)
          report_mismatch("payload_out", payload_out_o, oldest.word);
        if (status_o !== oldest.status)
          report_mismatch("status", WORD_BITS'(status_o), WORD_BITS'(oldest.status));
        if (entry_count_o !== oldest.count)
          report_mismatch("entry_count", WORD_BITS'(entry_count_o), WORD_BITS'(oldest.count));
        if (is_empty_o !== oldest.empty)
          report_mismatch("is_empty", WORD_BITS'(is_empty_o), WORD_BITS'(oldest.empty));
      end
    end
  end

  // hold the request until accepted, then idle at random
  task automatic send_request(input op_e op, input logic [POS_BITS-1:0] pos,
                              input logic [WORD_BITS-1:0] data);
    operation_i  <= op;
    position_i   <= pos;
    payload_in_i <= data;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_outcomes.push_back(predict_queue_op(op, pos, data));
    requests_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    send_request(OP_DEQ, 6'd0, 32'h1234_5678);
    send_request(OP_REM, 6'd0, 32'h0);
    send_request(OP_REM, 6'd63, 32'h0);
    send_request(OP_INS, 6'd1, 32'hDEAD_BEEF);
    send_request(OP_INS, 6'd0, 32'h0000_0000);
    send_request(OP_ENQ, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_INS, 6'd0, 32'hA5A5_A5A5);
    send_request(OP_INS, 6'd3, 32'h5A5A_5A5A);
    send_request(OP_INS, 6'd2, 32'h0000_0001);
    send_request(OP_INS, 6'd6, 32'hCAFE_0000);
    send_request(OP_INS, 6'd63, 32'hCAFE_0001);
    send_request(OP_REM, 6'd5, 32'h0);
    send_request(OP_REM, 6'd4, 32'h0);
    send_request(OP_REM, 6'd0, 32'h0);
    send_request(OP_REM, 6'd1, 32'h0);
    send_request(OP_DEQ, 6'd0, 32'h0);
    send_request(OP_DEQ, 6'd42, 32'h0);
    send_request(OP_DEQ, 6'd0, 32'h0);
    send_request(OP_ENQ, 6'd0, 32'h8000_0000);
    send_request(OP_DEQ, 6'd0, 32'h0);
  endtask

  task automatic test_full_queue();
    while (held_words.size() < QDEPTH) send_request(OP_ENQ, 6'($urandom_range(63)), $urandom);
    send_request(OP_ENQ, 6'd0, $urandom);
    send_request(OP_INS, 6'd5, $urandom);
    send_request(OP_INS, 6'(QDEPTH), $urandom);
    send_request(OP_INS, 6'(QDEPTH + 1), $urandom);
    send_request(OP_INS, 6'd63, $urandom);
    send_request(OP_REM, 6'(QDEPTH - 1), 32'h0);
    send_request(OP_REM, 6'(QDEPTH - 1), 32'h0);
    send_request(OP_INS, 6'd0, $urandom);
    send_request(OP_REM, 6'(QDEPTH), 32'h0);
    send_request(OP_INS, 6'd0, $urandom);
    while (held_words.size() > 0) begin
      if ($urandom_range(1)) send_request(OP_DEQ, 6'd0, 32'h0);
      else send_request(OP_REM, 6'($urandom_range(held_words.size() - 1)), 32'h0);
    end
    send_request(OP_DEQ, 6'd0, 32'h0);
  endtask

  // swing the fill level between empty and full with mostly legal positions
  task automatic test_random(input int unsigned pct, input int unsigned items);
    op_e                  op;
    logic [POS_BITS-1:0]  pos;
    logic [WORD_BITS-1:0] data;
    int unsigned          n;
    int unsigned          grow;
    idle_pct = pct;
    for (int unsigned k = 0; k < items; k++) begin
      n    = held_words.size();
      grow = ((k / 80) % 2 == 0) ? 75 : 25;
      if ($urandom_range(99) < grow) op = $urandom_range(1) ? OP_INS : OP_ENQ;
      else op = $urandom_range(1) ? OP_REM : OP_DEQ;
      pos = 6'($urandom_range(63));
      if (op == OP_INS && $urandom_range(7) != 0) pos = 6'($urandom_range(n));
      if (op == OP_REM && n > 0 && $urandom_range(7) != 0) pos = 6'($urandom_range(n - 1));
      case ($urandom_range(15))
        0:       data = '0;
        1:       data = '1;
        default: data = $urandom;
      endcase
      send_request(op, pos, data);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_queue();
    test_random(0, 420);
    test_random(81, 420);
    test_random(25, 420);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests and %0d results, deepest fill %0d of %0d entries",
             requests_sent, results_checked, deepest_fill, QDEPTH);
    $display("status mix: ok %0d, empty %0d, range %0d, full %0d, mismatches %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             status_seen[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ipq_pkg.sv
src/ipq_ram.sv
src/indexed_packet_queue_top.sv
tb/sv/tb_top.sv
